// ===== src/prrs_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// prrs_pkg: shared types and constants
// Types, operation codes and thread status codes for the ready-queue
// scheduler.
// ---------------------------------------------------------------------------
package prrs_pkg;

    localparam int NUM_PRIORITIES = 64;
    localparam int MAX_THREADS    = 32;
    localparam int PRIO_W = $clog2(NUM_PRIORITIES);
    localparam int TID_W  = $clog2(MAX_THREADS);
    localparam int LINK_W = TID_W + 1;

    localparam logic [LINK_W-1:0] NONE_ID = LINK_W'(MAX_THREADS);

    localparam logic [1:0] KIND_APPEND   = 2'd0;
    localparam logic [1:0] KIND_REMOVE   = 2'd1;
    localparam logic [1:0] KIND_SCHEDULE = 2'd2;

    localparam logic [1:0] ST_UNQUEUED = 2'd0;
    localparam logic [1:0] ST_READY    = 2'd1;
    localparam logic [1:0] ST_RUNNING  = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [TID_W-1:0]  thread_id;
        logic [PRIO_W-1:0] priority_req;
    } sched_in_t;

    typedef struct packed {
        logic              switched;
        logic [TID_W-1:0]  chosen_thread;
        logic              chosen_valid;
        logic [TID_W-1:0]  previous_thread;
        logic              previous_valid;
        logic              restart_slice_timer;
        logic              stop_previous_timer;
        logic              op_error;
    } sched_out_t;

    // Per-thread record held in the thread memory.
    typedef struct packed {
        logic [LINK_W-1:0] fwd;
        logic [LINK_W-1:0] bwd;
        logic [PRIO_W-1:0] prio;
    } thread_rec_t;

    // Per-level record held in the queue memory.
    typedef struct packed {
        logic [LINK_W-1:0] head;
        logic [LINK_W-1:0] tail;
    } level_rec_t;

endpackage : prrs_pkg
`default_nettype wire

// ===== src/prrs_prio_find.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// prrs_prio_find: highest non-empty level search
// Registered search of the non-empty map for the highest set bit, split
// into groups of eight so each cycle resolves a narrow priority encode.
// ---------------------------------------------------------------------------
module prrs_prio_find
    import prrs_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [NUM_PRIORITIES-1:0] map,
    output logic                           found,
    output logic [PRIO_W-1:0]              level
);

    localparam int GROUPS = (NUM_PRIORITIES + 7) / 8;
    localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    logic [GROUPS-1:0] grp_any_reg;
    logic [GROUPS-1:0] grp_any_next;
    logic [GROUPS-1:0][2:0] grp_pos_reg;
    logic [GROUPS-1:0][2:0] grp_pos_next;

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_any_next[g] = 1'b0;
            grp_pos_next[g] = 3'd0;
            for (int b = 0; b < 8; b++)
            begin
                if (g * 8 + b < NUM_PRIORITIES)
                begin
                    if (map[g * 8 + b])
                    begin
                        grp_any_next[g] = 1'b1;
                        grp_pos_next[g] = 3'(b);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_any_reg <= '0;
            grp_pos_reg <= '0;
        end
        else
        begin
            grp_any_reg <= grp_any_next;
            grp_pos_reg <= grp_pos_next;
        end
    end

    logic [GRP_W-1:0] grp_sel;

    always_comb
    begin
        found   = 1'b0;
        grp_sel = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            if (grp_any_reg[g])
            begin
                found   = 1'b1;
                grp_sel = GRP_W'(g);
            end
        end
        level = PRIO_W'({grp_sel, grp_pos_reg[grp_sel]});
    end

endmodule : prrs_prio_find
`default_nettype wire

// ===== src/priority_round_robin_scheduler_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// priority_round_robin_scheduler_top: RTOS ready-queue scheduler
// 64 priority levels of doubly linked round-robin FIFOs of thread ids.
// ---------------------------------------------------------------------------
// Sequencing: busy is high while a command is in progress and falls in the
// cycle in which done strobes. A schedule rotates the chosen head to the tail
// of its level unless it is the only thread there. A new command is taken
// only while idle, so it can follow in the done cycle. Results cannot stall.
// Reset clears control state, status and the non-empty map; no clearing pass.
// ---------------------------------------------------------------------------
module priority_round_robin_scheduler_top
    import prrs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire sched_in_t cmd,
    output logic           busy,
    output logic           done,
    output sched_out_t     result
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ERR     = 4'd1;   // flag an illegal command
    localparam logic [3:0] S_U_RD    = 4'd2;   // unlink: read thread record
    localparam logic [3:0] S_U_REC   = 4'd3;   // unlink: read level and back neighbor
    localparam logic [3:0] S_U_B     = 4'd4;   // unlink: fix back neighbor
    localparam logic [3:0] S_U_F     = 4'd5;   // unlink: fix forward neighbor and level
    localparam logic [3:0] S_A_RD    = 4'd6;   // append: read level record
    localparam logic [3:0] S_A_LVL   = 4'd7;   // append: read old tail
    localparam logic [3:0] S_A_TAIL  = 4'd8;   // append: link old tail forward
    localparam logic [3:0] S_A_NEW   = 4'd9;   // append: write new tail and level
    localparam logic [3:0] S_SC_FIND = 4'd10;
    localparam logic [3:0] S_SC_HEAD = 4'd11;
    localparam logic [3:0] S_SC_FIN  = 4'd12;
    localparam logic [3:0] S_DONE    = 4'd13;

    logic [3:0] state_reg;
    sched_in_t  cmd_reg;
    sched_out_t res_reg;
    logic       done_reg;

    logic [NUM_PRIORITIES-1:0] map_reg;
    logic [MAX_THREADS-1:0][1:0] status_reg;
    logic [TID_W-1:0] run_id_reg;
    logic             run_present_reg;

    // Thread memory: links and priority.
    thread_rec_t tmem [MAX_THREADS];
    thread_rec_t t_rdata;
    logic [TID_W-1:0] t_raddr;
    logic             t_we;
    logic [TID_W-1:0] t_waddr;
    thread_rec_t      t_wdata;

    // Level memory: head and tail.
    level_rec_t lmem [NUM_PRIORITIES];
    level_rec_t l_rdata;
    logic [PRIO_W-1:0] l_raddr;
    logic              l_we;
    logic [PRIO_W-1:0] l_waddr;
    level_rec_t        l_wdata;

    always_ff @(posedge clk)
    begin
        if (t_we)
            tmem[t_waddr] <= t_wdata;
        t_rdata <= tmem[t_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (l_we)
            lmem[l_waddr] <= l_wdata;
        l_rdata <= lmem[l_raddr];
    end

    // Working registers.
    thread_rec_t      rec_reg;     // record of the thread being unlinked
    logic [PRIO_W-1:0] lvl_reg;
    level_rec_t       lrec_reg;
    logic [TID_W-1:0] to_reg;
    logic             rotate_reg;  // schedule: unlink the head, then append it

    logic             pf_found;
    logic [PRIO_W-1:0] pf_level;

    prrs_prio_find u_find (
        .clk   (clk),
        .rst_n (rst_n),
        .map   (map_reg),
        .found (pf_found),
        .level (pf_level)
    );

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    logic [TID_W-1:0] cur_t;
    assign cur_t = rotate_reg ? to_reg : cmd_reg.thread_id;

    always_comb
    begin
        t_raddr = cur_t;
        l_raddr = lvl_reg;
        t_we = 1'b0; t_waddr = cur_t; t_wdata = rec_reg;
        l_we = 1'b0; l_waddr = lvl_reg; l_wdata = lrec_reg;
        unique case (state_reg)
            S_U_REC:
            begin
                l_raddr = t_rdata.prio;
                t_raddr = t_rdata.bwd[TID_W-1:0];
            end
            S_U_B:
            begin
                if (rec_reg.bwd != NONE_ID)
                begin
                    t_we = 1'b1;
                    t_waddr = rec_reg.bwd[TID_W-1:0];
                    t_wdata = t_rdata;
                    t_wdata.fwd = rec_reg.fwd;
                end
                t_raddr = rec_reg.fwd[TID_W-1:0];
            end
            S_U_F:
            begin
                if (rec_reg.fwd != NONE_ID)
                begin
                    t_we = 1'b1;
                    t_waddr = rec_reg.fwd[TID_W-1:0];
                    t_wdata = t_rdata;
                    t_wdata.bwd = rec_reg.bwd;
                end
                l_we = 1'b1;
                l_wdata.head = (rec_reg.bwd == NONE_ID) ? rec_reg.fwd : lrec_reg.head;
                l_wdata.tail = (rec_reg.fwd == NONE_ID) ? rec_reg.bwd : lrec_reg.tail;
            end
            S_A_LVL:
            begin
                if (map_reg[lvl_reg])
                begin
                    t_raddr = l_rdata.tail[TID_W-1:0];
                end
                else
                begin
                    // Empty level: the thread becomes both head and tail.
                    t_we = 1'b1;
                    t_wdata.fwd  = NONE_ID;
                    t_wdata.bwd  = NONE_ID;
                    t_wdata.prio = lvl_reg;
                    l_we = 1'b1;
                    l_wdata.head = LINK_W'(cur_t);
                    l_wdata.tail = LINK_W'(cur_t);
                end
            end
            S_A_TAIL:
            begin
                t_we = 1'b1;
                t_waddr = lrec_reg.tail[TID_W-1:0];
                t_wdata = t_rdata;
                t_wdata.fwd = LINK_W'(cur_t);
            end
            S_A_NEW:
            begin
                t_we = 1'b1;
                t_wdata.fwd  = NONE_ID;
                t_wdata.bwd  = lrec_reg.tail;
                t_wdata.prio = lvl_reg;
                l_we = 1'b1;
                l_wdata.head = lrec_reg.head;
                l_wdata.tail = LINK_W'(cur_t);
            end
            S_SC_FIND:
            begin
                l_raddr = pf_level;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            done_reg        <= 1'b0;
            map_reg         <= '0;
            status_reg      <= '0;
            run_id_reg      <= '0;
            run_present_reg <= 1'b0;
            rotate_reg      <= 1'b0;
            cmd_reg         <= '0;
            res_reg         <= '0;
            rec_reg         <= '0;
            lvl_reg         <= '0;
            lrec_reg        <= '0;
            to_reg          <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg    <= cmd;
                        res_reg    <= '0;
                        rotate_reg <= 1'b0;
                        lvl_reg    <= cmd.priority_req;
                        unique case (cmd.kind)
                            KIND_APPEND:
                            begin
                                if (status_reg[cmd.thread_id] != ST_UNQUEUED)
                                    state_reg <= S_ERR;
                                else
                                    state_reg <= S_A_RD;
                            end
                            KIND_REMOVE:
                            begin
                                if (status_reg[cmd.thread_id] == ST_UNQUEUED)
                                    state_reg <= S_ERR;
                                else
                                    state_reg <= S_U_RD;
                            end
                            KIND_SCHEDULE:
                            begin
                                state_reg <= S_SC_FIND;
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_ERR:
                begin
                    res_reg.op_error <= 1'b1;
                    state_reg <= S_DONE;
                end
                S_U_RD:
                begin
                    state_reg <= S_U_REC;
                end
                S_U_REC:
                begin
                    // A head with no successor is already at the tail.
                    if (rotate_reg && t_rdata.fwd == NONE_ID)
                    begin
                        rotate_reg <= 1'b0;
                        state_reg  <= S_SC_FIN;
                    end
                    else
                    begin
                        rec_reg   <= t_rdata;
                        lvl_reg   <= t_rdata.prio;
                        state_reg <= S_U_B;
                    end
                end
                S_U_B:
                begin
                    lrec_reg  <= l_rdata;
                    state_reg <= S_U_F;
                end
                S_U_F:
                begin
                    if (rec_reg.fwd == NONE_ID && rec_reg.bwd == NONE_ID)
                        map_reg[lvl_reg] <= 1'b0;
                    if (rotate_reg)
                        state_reg <= S_A_RD;
                    else
                    begin
                        status_reg[cur_t] <= ST_UNQUEUED;
                        state_reg <= S_DONE;
                    end
                end
                S_A_RD:
                begin
                    state_reg <= S_A_LVL;
                end
                S_A_LVL:
                begin
                    lrec_reg <= l_rdata;
                    if (map_reg[lvl_reg])
                        state_reg <= S_A_TAIL;
                    else
                    begin
                        map_reg[lvl_reg] <= 1'b1;
                        if (!rotate_reg)
                            status_reg[cur_t] <= ST_READY;
                        state_reg <= rotate_reg ? S_SC_FIN : S_DONE;
                    end
                end
                S_A_TAIL:
                begin
                    state_reg <= S_A_NEW;
                end
                S_A_NEW:
                begin
                    if (!rotate_reg)
                        status_reg[cur_t] <= ST_READY;
                    state_reg <= rotate_reg ? S_SC_FIN : S_DONE;
                end
                S_SC_FIND:
                begin
                    if (run_present_reg)
                    begin
                        res_reg.previous_thread <= run_id_reg;
                        res_reg.previous_valid  <= 1'b1;
                    end
                    lvl_reg   <= pf_level;
                    state_reg <= pf_found ? S_SC_HEAD : S_DONE;
                end
                S_SC_HEAD:
                begin
                    to_reg     <= l_rdata.head[TID_W-1:0];
                    rotate_reg <= 1'b1;
                    state_reg  <= S_U_RD;
                end
                S_SC_FIN:
                begin
                    rotate_reg <= 1'b0;
                    res_reg.chosen_thread <= to_reg;
                    res_reg.chosen_valid  <= 1'b1;
                    if (!run_present_reg || run_id_reg != to_reg)
                    begin
                        res_reg.switched            <= 1'b1;
                        res_reg.restart_slice_timer <= 1'b1;
                        if (run_present_reg && status_reg[run_id_reg] == ST_RUNNING)
                        begin
                            res_reg.stop_previous_timer <= 1'b1;
                            status_reg[run_id_reg] <= ST_READY;
                        end
                        status_reg[to_reg] <= ST_RUNNING;
                        run_id_reg      <= to_reg;
                        run_present_reg <= 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_busy_before_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while still busy");

    a_chosen_running: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.switched) |-> (run_present_reg && run_id_reg == result.chosen_thread))
        else $error("switched result does not match running thread");
`endif

endmodule : priority_round_robin_scheduler_top
`default_nettype wire
